/* sv/assert_macros.svh */
// Assertion macros for the RTL files.
// ASSERT_CLK expects signals clk and arst_n in the enclosing scope; ASSERT_ALWAYS needs only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked on clk, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion that also checks during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pvfd_pkg.sv */
// Package for the prefix varint field decoder: phase and result kind types,
// sizing constants and the leading-ones count. No dependencies.
package pvfd_pkg;

	localparam int PVFD_VALUE_BITS = 32;
	localparam int PVFD_OUT_BITS = 32;
	localparam int PVFD_TAIL_BITS = 4;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_TAIL    = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		KIND_INT   = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_EMPTY = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	function automatic logic [PVFD_TAIL_BITS-1:0] lead_ones(input logic [7:0] b);
		logic [PVFD_TAIL_BITS-1:0] n;
		logic                      run;
		n = '0;
		run = 1'b1;
		for (int i = 7; i >= 0; i--) begin
			run = run & b[i];
			if (run) begin
				n = n + 1'b1;
			end
		end
		return n;
	endfunction

endpackage

/* sv/pvfd_if.sv */
// Valid/ready channel interfaces of the prefix varint field decoder.
// Depends on nothing; the top level uses both.
interface pvfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       func;
	logic       packet_last;

	modport source (output valid, output in_byte, output func, output packet_last,
		input ready);
	modport sink (input valid, input in_byte, input func, input packet_last,
		output ready);
endinterface

interface pvfd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] value;
	logic        string_end;

	modport source (output valid, output kind, output value, output string_end,
		input ready);
	modport sink (input valid, input kind, input value, input string_end,
		output ready);
endinterface

/* sv/prefix_varint_field_decoder_top.sv */
// Prefix varint field decoder: one packet byte per beat in, zero or one result per beat out.
// Depends on pvfd_pkg, the channel interfaces in pvfd_if.sv and assert_macros.svh.
//
// Usage:
//   rx carries packet bytes with func (field kind, sampled on a field's first byte)
//   and packet_last. tx carries results: integer done, string byte (string_end on
//   the final payload byte), empty string, or truncation error.
//   A byte accepted from rx is held in the input register and decoded from there; its
//   result, if any, is loaded into the tx register when the input register advances,
//   which waits while the tx register holds a result that tx has not taken.
//   Throughput is one byte per cycle while tx does not stall; the field state register
//   is updated by a single pass of shallow logic per byte, so the state loop sets that figure.
//   Reset clears the field state and both pipeline valids; the next byte starts
//   a new field. When tx stalls, the result register holds and one more byte
//   waits in the input register; rx.ready drops only when both are occupied.
//   A packet that ends inside a field yields one error result on its last byte,
//   and string bytes already passed on stay delivered.
`include "assert_macros.svh"

module prefix_varint_field_decoder_top
	import pvfd_pkg::*;
#(
	parameter int VALUE_BITS = PVFD_VALUE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	pvfd_byte_if.sink          rx,
	pvfd_result_if.source      tx
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       func_s1;
	logic       last_s1;
	logic       adv;

	phase_t                    phase_q, phase_d;
	logic [PVFD_TAIL_BITS-1:0] tail_q, tail_d;
	logic [VALUE_BITS-1:0]     acc_q, acc_d;
	logic                      is_str_q, is_str_d;
	logic [VALUE_BITS-1:0]     pl_q, pl_d;

	logic                      fin;
	logic                      fail;
	logic [PVFD_TAIL_BITS-1:0] ones;
	logic                      produce;
	kind_t                     r_kind;
	logic [PVFD_OUT_BITS-1:0]  r_val;
	logic                      r_end;

	logic                      out_valid_q;
	kind_t                     kind_q;
	logic [PVFD_OUT_BITS-1:0]  value_q;
	logic                      end_q;

	assign adv = valid_s1 && (!out_valid_q || tx.ready);
	assign rx.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.in_byte;
			func_s1 <= rx.func;
			last_s1 <= rx.packet_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tail_q   <= '0;
			acc_q    <= '0;
			is_str_q <= 1'b0;
			pl_q     <= '0;
		end else if (adv) begin
			phase_q  <= phase_d;
			tail_q   <= tail_d;
			acc_q    <= acc_d;
			is_str_q <= is_str_d;
			pl_q     <= pl_d;
		end
	end

	assign ones = lead_ones(byte_s1);

	always_comb begin
		phase_d  = phase_q;
		tail_d   = tail_q;
		acc_d    = acc_q;
		is_str_d = is_str_q;
		pl_d     = pl_q;
		fin      = 1'b0;
		fail     = 1'b0;
		produce  = 1'b0;
		r_kind   = KIND_INT;
		r_val    = '0;
		r_end    = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				is_str_d = func_s1;
				acc_d = (ones >= PVFD_TAIL_BITS'(8)) ? '0 :
					VALUE_BITS'(byte_s1 & (8'hFF >> ones));
				if (ones == '0) begin
					fin = 1'b1;
				end else begin
					tail_d  = ones;
					phase_d = PH_TAIL;
				end
			end
			PH_TAIL: begin
				acc_d  = VALUE_BITS'({acc_q, byte_s1});
				tail_d = tail_q - 1'b1;
				if (tail_d == '0) begin
					fin = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (last_s1 && pl_q > VALUE_BITS'(1)) begin
					fail = 1'b1;
				end else begin
					produce = 1'b1;
					r_kind  = KIND_BYTE;
					r_val   = PVFD_OUT_BITS'(byte_s1);
					r_end   = (pl_q <= VALUE_BITS'(1));
					pl_d    = pl_q - 1'b1;
					if (pl_d == '0) begin
						phase_d = PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (fin) begin
			phase_d = PH_IDLE;
			tail_d  = '0;
			if (!is_str_d) begin
				produce = 1'b1;
				r_kind  = KIND_INT;
				r_val   = PVFD_OUT_BITS'(acc_d);
			end else if (acc_d == '0) begin
				produce = 1'b1;
				r_kind  = KIND_EMPTY;
			end else begin
				pl_d    = acc_d;
				phase_d = PH_PAYLOAD;
			end
		end

		if (last_s1) begin
			if (fail || phase_d != PH_IDLE) begin
				produce = 1'b1;
				r_kind  = KIND_ERROR;
				r_val   = '0;
				r_end   = 1'b0;
			end
			phase_d  = PH_IDLE;
			tail_d   = '0;
			acc_d    = '0;
			is_str_d = 1'b0;
			pl_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= produce;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && produce) begin
			kind_q  <= r_kind;
			value_q <= r_val;
			end_q   <= r_end;
		end
	end

	assign tx.valid      = out_valid_q;
	assign tx.kind       = kind_q;
	assign tx.value      = value_q;
	assign tx.string_end = end_q;

	`ASSERT_CLK(a_payload_nonzero, (phase_q == PH_PAYLOAD) |-> (pl_q != '0), "payload count zero in payload phase")
	`ASSERT_CLK(a_tail_range, (phase_q == PH_TAIL) |-> (tail_q != '0 && tail_q <= PVFD_TAIL_BITS'(8)), "tail count out of range")
	`ASSERT_CLK(a_last_idles, (adv && last_s1) |=> (phase_q == PH_IDLE && pl_q == '0), "state not cleared at packet end")
	`ASSERT_CLK(a_end_on_byte, (out_valid_q && end_q) |-> (kind_q == KIND_BYTE), "string end on non-byte result")
	`ASSERT_ALWAYS(a_ready_when_empty, (!valid_s1) |-> rx.ready, "input stage empty but not ready")

endmodule

/* tb/sv/tb_top.sv */
// Testbench for prefix_varint_field_decoder_top: directed fields, then random packets.
// Self-checking against its own decoder model in a scoreboard class.
// Depends on pvfd_pkg, pvfd_if.sv and the decoder RTL.
module tb_top;
	import pvfd_pkg::*;

	localparam int unsigned RANDOM_BEATS = 1950;
	localparam int unsigned LIMIT_CYCLES = 2_000_000;
	localparam int unsigned SETTLE_CYCLES = 10;

	typedef struct {
		kind_t       kind;
		logic [31:0] value;
		logic        string_end;
	} field_result_t;

	typedef struct {
		logic [7:0] data;
		logic       fn;
	} beat_t;

	class field_decode_sb;
		phase_t        phase;
		int unsigned   tail_left;
		logic [31:0]   accum;
		bit            is_string;
		logic [31:0]   payload_left;
		bit            failed;
		field_result_t decoded_q[$];
		int unsigned   errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			phase = PH_IDLE;
			tail_left = 0;
			accum = '0;
			is_string = 0;
			payload_left = '0;
			failed = 0;
		endfunction

		function void close_value(output bit hit, output field_result_t r);
			hit = 0;
			r = '{KIND_INT, 32'd0, 1'b0};
			phase = PH_IDLE;
			tail_left = 0;
			if (!is_string) begin
				r = '{KIND_INT, accum, 1'b0};
				hit = 1;
			end else if (accum == 0) begin
				r = '{KIND_EMPTY, 32'd0, 1'b0};
				hit = 1;
			end else begin
				payload_left = accum;
				phase = PH_PAYLOAD;
			end
		endfunction

		function void note_byte(logic [7:0] b, logic fn, logic last);
			field_result_t r;
			bit            hit;
			int unsigned   ones;
			hit = 0;
			r = '{KIND_INT, 32'd0, 1'b0};
			if (failed) begin
				if (last) clear();
				return;
			end
			case (phase)
				PH_IDLE: begin
					ones = 0;
					while (ones < 8 && b[7 - ones]) ones++;
					is_string = fn;
					accum = (ones >= 8) ? 32'd0 : 32'(b & (8'hFF >> ones));
					if (ones == 0) begin
						close_value(hit, r);
					end else begin
						tail_left = ones;
						phase = PH_TAIL;
					end
				end
				PH_TAIL: begin
					accum = {accum[23:0], b};
					if (tail_left > 0) tail_left--;
					if (tail_left == 0) close_value(hit, r);
				end
				PH_PAYLOAD: begin
					if (last && payload_left > 1) begin
						failed = 1;
					end else begin
						r = '{KIND_BYTE, 32'(b), payload_left <= 1};
						hit = 1;
						if (payload_left > 0) payload_left--;
						if (payload_left == 0) phase = PH_IDLE;
					end
				end
				default: begin
					phase = PH_IDLE;
				end
			endcase
			if (last) begin
				if (failed || phase != PH_IDLE) begin
					r = '{KIND_ERROR, 32'd0, 1'b0};
					hit = 1;
				end
				clear();
			end
			if (hit) decoded_q.insert(decoded_q.size(), r);
		endfunction

		function void check_result(logic [1:0] kind, logic [31:0] value, logic string_end);
			field_result_t r;
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected result kind %0d value %0h string_end %0b",
					$time, kind, value, string_end);
				errors++;
				return;
			end
			r = decoded_q.pop_front();
			if (kind !== r.kind) begin
				$display("%0t: kind mismatch, expected %0d, actual %0d", $time, r.kind, kind);
				errors++;
			end
			if (value !== r.value) begin
				$display("%0t: value mismatch, expected %0h, actual %0h", $time, r.value, value);
				errors++;
			end
			if (string_end !== r.string_end) begin
				$display("%0t: string_end mismatch, expected %0b, actual %0b",
					$time, r.string_end, string_end);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return decoded_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pvfd_byte_if   rx_if ();
	pvfd_result_if tx_if ();

	prefix_varint_field_decoder_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.tx     (tx_if)
	);

	field_decode_sb sb = new();
	beat_t          pkt[$];
	bit             calm;
	int unsigned    beats_sent;
	int unsigned    cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic fn, input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.in_byte <= b;
		rx_if.func <= fn;
		rx_if.packet_last <= last;
		do @(posedge clk); while (!rx_if.ready);
		sb.note_byte(b, fn, last);
		beats_sent++;
	endtask

	// hold off the sender until every expected result is out
	task automatic drain();
		rx_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic void add_beat(logic [7:0] d, logic fn);
		beat_t bt;
		bt.data = d;
		bt.fn = fn;
		pkt.insert(pkt.size(), bt);
	endfunction

	function automatic void add_prefix(int unsigned n, logic [7:0] bits, logic fn);
		logic [7:0] first;
		logic [7:0] ones_mask;
		ones_mask = 8'hFF;
		ones_mask = ones_mask << (8 - n);
		if (n >= 8) first = 8'hFF;
		else first = ones_mask | (bits & (8'hFF >> (n + 1)));
		add_beat(first, fn);
	endfunction

	function automatic void add_int_field();
		int unsigned n;
		n = $urandom_range(0, 8);
		add_prefix(n, 8'($urandom), 1'b0);
		repeat (n) add_beat(8'($urandom), 1'($urandom));
	endfunction

	// length sits in the low 32 bits; bytes shifted out above them are random
	function automatic void add_string_field();
		int unsigned n;
		int unsigned len;
		int unsigned r;
		int unsigned j;
		logic [7:0]  bits;
		r = $urandom_range(0, 99);
		if (r < 70) len = $urandom_range(0, 4);
		else if (r < 95) len = $urandom_range(5, 16);
		else len = $urandom_range(17, 40);
		n = $urandom_range(0, 8);
		bits = (n >= 4) ? 8'($urandom) : 8'(len >> (8 * n));
		add_prefix(n, bits, 1'b1);
		for (int k = 0; k < n; k++) begin
			j = n - 1 - k;
			add_beat((j < 4) ? 8'(len >> (8 * j)) : 8'($urandom), 1'($urandom));
		end
		repeat (len) add_beat(8'($urandom), 1'($urandom));
	endfunction

	task automatic send_packet();
		foreach (pkt[i]) send_beat(pkt[i].data, pkt[i].fn, i == pkt.size() - 1);
		pkt.delete();
	endtask

	task automatic random_packet();
		int unsigned r;
		int unsigned cut;
		r = $urandom_range(0, 99);
		if (r < 80) begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(0, 1)) add_string_field();
				else add_int_field();
			end
		end else if (r < 90) begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 1)) add_string_field();
				else add_int_field();
			end
			if (pkt.size() > 1) begin
				cut = $urandom_range(1, pkt.size() - 1);
				while (pkt.size() > cut) pkt.pop_back();
			end
		end else begin
			repeat ($urandom_range(1, 8)) add_beat(8'($urandom), 1'($urandom));
		end
		send_packet();
	endtask

	initial begin
		int unsigned gap;
		wait (arst_n === 1'b1);
		forever begin
			tx_if.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			gap = pick_gap();
			if (gap > 0) begin
				tx_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && tx_if.valid && tx_if.ready)
			sb.check_result(tx_if.kind, tx_if.value, tx_if.string_end);
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int unsigned start;
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.in_byte = 8'd0;
		rx_if.func = 1'b0;
		rx_if.packet_last = 1'b0;
		tx_if.ready = 1'b0;
		calm = 0;
		beats_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_beat(8'h00, 1'b0, 1'b0);
		send_beat(8'h7F, 1'b0, 1'b0);
		send_beat(8'hBF, 1'b0, 1'b0);
		send_beat(8'hFF, 1'b0, 1'b0);
		send_beat(8'hFF, 1'b1, 1'b0);
		for (int k = 1; k <= 8; k++) send_beat(8'(k), 1'b0, 1'b0);
		send_beat(8'h00, 1'b1, 1'b0);
		send_beat(8'h02, 1'b1, 1'b0);
		send_beat(8'hA5, 1'b0, 1'b0);
		send_beat(8'h5A, 1'b1, 1'b0);
		send_beat(8'hC0, 1'b0, 1'b1);
		send_beat(8'h03, 1'b1, 1'b0);
		send_beat(8'h11, 1'b0, 1'b0);
		send_beat(8'h22, 1'b0, 1'b1);
		send_beat(8'h05, 1'b1, 1'b1);
		send_beat(8'h00, 1'b0, 1'b1);
		send_beat(8'h01, 1'b1, 1'b0);
		send_beat(8'h77, 1'b0, 1'b1);
		drain();

		start = beats_sent;
		while (beats_sent - start < RANDOM_BEATS) begin
			calm = ($urandom_range(0, 9) == 0);
			random_packet();
			if ($urandom_range(0, 39) == 0) drain();
		end
		calm = 0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+sv
sv/pvfd_pkg.sv
sv/pvfd_if.sv
sv/prefix_varint_field_decoder_top.sv
tb/sv/tb_top.sv
